@@ src/segment_capsule_query_core_macros.svh @@
// assertion macros used by the checker file
`ifndef SEGMENT_CAPSULE_QUERY_CORE_MACROS_SVH
`define SEGMENT_CAPSULE_QUERY_CORE_MACROS_SVH

// checked only while out of reset
`define SCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SCQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/scq_pkg.sv @@
// ----------------------------------------------------------------------------
// scq_pkg
// Types, constants and helper functions of the segment capsule query core.
// ----------------------------------------------------------------------------
package scq_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int ROT_FRAC_BITS   = 14;

	// squared length below which the segment counts as a point
	localparam logic [65:0] EPS_SQ =
		66'(((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd5000) / 64'd10000);
	localparam int EPS_LEN_RAW = ((1 << COORD_FRAC_BITS) + 5000) / 10000;
	localparam int EPS_LEN     = (EPS_LEN_RAW == 0) ? 1 : EPS_LEN_RAW;
	localparam logic [65:0] EPS_LEN_SQ = 66'(EPS_LEN * EPS_LEN);

	localparam logic signed [15:0] ONE_ROT =
		(ROT_FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << ROT_FRAC_BITS);
	localparam logic signed [31:0] ONE_COORD = 32'(1 << COORD_FRAC_BITS);
	localparam logic [16:0] T_ONE = 17'h10000;

	localparam int MW = 36;
	localparam int PW = 2 * MW;

	localparam logic [4:0] XF_PRODUCTS   = 5'd18;
	localparam logic [4:0] QM_PRODUCTS   = 5'd6;
	localparam logic [4:0] RAY_PRODUCTS  = 5'd3;
	localparam logic [4:0] DIST_PRODUCTS = 5'd7;
	localparam logic [4:0] DIV_STEPS     = 5'd16;
	localparam logic [5:0] SQ_LAST       = 6'd35;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] rot_t;
	typedef logic signed [MW-1:0] mop_t;
	typedef logic signed [PW-1:0] mprod_t;

	typedef enum logic [1:0] {
		CMD_ROW    = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_START_X   = 3'd0,
		REG_START_Y   = 3'd1,
		REG_START_Z   = 3'd2,
		REG_END_X     = 3'd3,
		REG_END_Y     = 3'd4,
		REG_END_Z     = 3'd5,
		REG_THICKNESS = 3'd6
	} reg_idx_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_XFORM = 8'b0000_0010,
		ST_QMUL  = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_RAY   = 8'b0001_0000,
		ST_DIST  = 8'b0010_0000,
		ST_SQRT  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic       ep;
		logic [1:0] col;
		logic [1:0] ri;
	} xf_sel_t;

	typedef struct packed {
		logic start;
		logic done;
	} sq_ctl_t;

	function automatic coord_t sat32(input logic signed [PW-1:0] v);
		coord_t r;
		if (v > 72'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -72'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic rot_t sat16(input coord_t v);
		rot_t r;
		if (v > 32'sd32767) r = 16'sd32767;
		else if (v < -32'sd32768) r = -16'sd32768;
		else r = v[15:0];
		return r;
	endfunction

	// product k of the transform: endpoint, output column, local axis
	function automatic xf_sel_t xf_dec(input logic [4:0] k);
		xf_sel_t s;
		logic [4:0] kk;
		logic [4:0] kr;
		s.ep = (k >= 5'd9);
		kk = s.ep ? (k - 5'd9) : k;
		if (kk >= 5'd6) begin
			s.col = 2'd2;
			kr = kk - 5'd6;
		end else if (kk >= 5'd3) begin
			s.col = 2'd1;
			kr = kk - 5'd3;
		end else begin
			s.col = 2'd0;
			kr = kk;
		end
		s.ri = kr[1:0];
		return s;
	endfunction

	function automatic logic [1:0] lane3(input logic [4:0] k);
		logic [1:0] r;
		case (k)
			5'd0, 5'd3: r = 2'd0;
			5'd1, 5'd4: r = 2'd1;
			5'd2, 5'd5: r = 2'd2;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

@@ src/scq_req_if.sv @@
// ----------------------------------------------------------------------------
// scq_req_if
// Command channel: command, row index and one vector.
// ----------------------------------------------------------------------------
interface scq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [1:0]         row_index;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;

	modport source (output valid, cmd, row_index, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, cmd, row_index, vec_x, vec_y, vec_z, output ready);
endinterface

@@ src/scq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// scq_rsp_if
// Result channel: bounding box or point query answer.
// ----------------------------------------------------------------------------
interface scq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] box_min_x;
	logic signed [31:0] box_min_y;
	logic signed [31:0] box_min_z;
	logic signed [31:0] box_max_x;
	logic signed [31:0] box_max_y;
	logic signed [31:0] box_max_z;
	logic signed [31:0] near_x;
	logic signed [31:0] near_y;
	logic signed [31:0] near_z;
	logic [30:0]        distance;
	logic               ray_hit;
	logic [16:0]        ray_t;

	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, near_x, near_y, near_z, distance, ray_hit, ray_t, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, near_x, near_y, near_z, distance, ray_hit, ray_t, output ready);
endinterface

@@ src/scq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// scq_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scq_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/scq_mul.sv @@
// ----------------------------------------------------------------------------
// scq_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module scq_mul (
	input  logic             clk,
	input  scq_pkg::mop_t    a,
	input  scq_pkg::mop_t    b,
	output scq_pkg::mprod_t  p
);
	scq_pkg::mprod_t p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;
endmodule

@@ src/scq_isqrt.sv @@
// ----------------------------------------------------------------------------
// scq_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module scq_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [71:0]         radicand,
	output logic                done,
	output logic [35:0]         root
);
	logic [71:0] val_q;
	logic [39:0] rem_q;
	logic [35:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [39:0] rem_sh;
	logic [39:0] trial;
	logic [39:0] rem_n;
	logic [35:0] root_n;

	always_comb begin
		rem_sh = {rem_q[37:0], val_q[71:70]};
		trial  = {2'b00, root_q, 2'b01};
		if (rem_sh >= trial) begin
			rem_n  = rem_sh - trial;
			root_n = {root_q[34:0], 1'b1};
		end else begin
			rem_n  = rem_sh;
			root_n = {root_q[34:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == scq_pkg::SQ_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[69:0], 2'b00};
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ src/segment_capsule_query_core.sv @@
// ----------------------------------------------------------------------------
// segment_capsule_query_core
// Capsule (thick 3D segment) unit in signed Q16.16: rotation load, world
// placement with a grown bounding box, and closest point queries.
// ----------------------------------------------------------------------------
// A row load gives no result. An update sends its 18 products one per cycle
// through the single shared 36x36 multiplier. A point query uses 6 products
// for length and projection, a 16-step restoring divide for t (skipped when
// t clamps), 3 products for the point on the segment, 7 for the squared
// distances and the squared radius, and a 36-step square root. Commands are
// taken only while the core is idle; a finished result waits in the output
// register, so the next command can be taken before the previous result is
// read.
module segment_capsule_query_core (
	input  logic       clk,
	input  logic       arst_n,
	scq_req_if.sink    req,
	scq_rsp_if.source  rsp,
	scq_cfg_if.sink    cfg
);
	scq_pkg::state_t  state_q;
	logic [4:0]       step_q;
	logic             is_query_q;

	scq_pkg::coord_t  start_q [3];
	scq_pkg::coord_t  end_q [3];
	logic [30:0]      thick_q;
	scq_pkg::rot_t    rot_q [3][3];
	scq_pkg::coord_t  ws_q [3];
	scq_pkg::coord_t  we_q [3];

	scq_pkg::coord_t    pos_q [3];
	logic signed [32:0] d_q [3];
	logic signed [32:0] w_q [3];
	logic signed [51:0] acc_q;
	logic [65:0]        len_q;
	logic signed [67:0] dot_q;
	logic [66:0]        rem_q;
	logic [16:0]        t_q;
	logic signed [34:0] ray_q [3];
	logic [69:0]        dn_q;
	logic [69:0]        dr_q;
	logic [61:0]        tsq_q;
	logic               ray_ok_q;
	logic               rng_q;
	logic               near_s_q;

	logic               rsp_valid_q;
	scq_pkg::coord_t    box_min_q [3];
	scq_pkg::coord_t    box_max_q [3];
	scq_pkg::coord_t    near_q [3];
	logic [30:0]        dist_q;
	logic               hit_q;
	logic [16:0]        rt_q;

	scq_pkg::mop_t      op_a;
	scq_pkg::mop_t      op_b;
	scq_pkg::mprod_t    prod;
	scq_pkg::sq_ctl_t   sq;
	logic [35:0]        sq_root;

	logic               req_fire;
	logic               out_load;
	logic [4:0]         cons;
	logic [1:0]         iss_ln;
	logic [1:0]         cons_ln;
	scq_pkg::xf_sel_t   xf_iss;
	scq_pkg::xf_sel_t   xf_cons;
	scq_pkg::coord_t    vin [3];
	logic signed [51:0] acc_n;
	logic signed [34:0] near_ln;
	logic signed [34:0] near_c [3];
	logic [66:0]        rem_sh;
	logic [66:0]        len_x;

	assign req.ready = (state_q == scq_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_load  = (state_q == scq_pkg::ST_OUT) && (!rsp_valid_q || rsp.ready);

	assign vin[0] = req.vec_x;
	assign vin[1] = req.vec_y;
	assign vin[2] = req.vec_z;

	assign cons    = step_q - 5'd1;
	assign iss_ln  = scq_pkg::lane3(step_q);
	assign cons_ln = scq_pkg::lane3(cons);
	assign xf_iss  = scq_pkg::xf_dec(step_q);
	assign xf_cons = scq_pkg::xf_dec(cons);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			near_c[c] = near_s_q ? 35'(ws_q[c]) : ray_q[c];
		end
	end
	assign near_ln = near_c[iss_ln];

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			scq_pkg::ST_XFORM: begin
				op_a = xf_iss.ep ? 36'(end_q[xf_iss.ri]) : 36'(start_q[xf_iss.ri]);
				op_b = 36'(rot_q[xf_iss.ri][xf_iss.col]);
			end
			scq_pkg::ST_QMUL: begin
				op_a = 36'(d_q[iss_ln]);
				op_b = (step_q < 5'd3) ? 36'(d_q[iss_ln]) : 36'(w_q[iss_ln]);
			end
			scq_pkg::ST_RAY: begin
				op_a = 36'(d_q[iss_ln]);
				op_b = signed'({19'd0, t_q});
			end
			scq_pkg::ST_DIST: begin
				if (step_q < 5'd3) begin
					op_a = 36'(pos_q[iss_ln]) - 36'(near_ln);
				end else if (step_q < 5'd6) begin
					op_a = 36'(pos_q[iss_ln]) - 36'(ray_q[iss_ln]);
				end else begin
					op_a = signed'({5'd0, thick_q});
				end
				op_b = op_a;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	scq_mul u_mul (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.p   (prod)
	);

	assign sq.start = (state_q == scq_pkg::ST_SQRT) && (step_q == 5'd0);

	scq_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq.start),
		.radicand ({2'b00, dn_q}),
		.done     (sq.done),
		.root     (sq_root)
	);

	assign acc_n  = (xf_cons.ri == 2'd0) ? prod[51:0] : (acc_q + prod[51:0]);
	assign rem_sh = {rem_q[65:0], 1'b0};
	assign len_x  = {1'b0, len_q};

	// control, architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scq_pkg::ST_IDLE;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
			thick_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				end_q[i]   <= (i == 1) ? scq_pkg::ONE_COORD : '0;
				ws_q[i]    <= '0;
				we_q[i]    <= (i == 1) ? scq_pkg::ONE_COORD : '0;
				for (int j = 0; j < 3; j++) begin
					rot_q[i][j] <= (i == j) ? scq_pkg::ONE_ROT : '0;
				end
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					scq_pkg::REG_START_X:   start_q[0] <= cfg.data;
					scq_pkg::REG_START_Y:   start_q[1] <= cfg.data;
					scq_pkg::REG_START_Z:   start_q[2] <= cfg.data;
					scq_pkg::REG_END_X:     end_q[0] <= cfg.data;
					scq_pkg::REG_END_Y:     end_q[1] <= cfg.data;
					scq_pkg::REG_END_Z:     end_q[2] <= cfg.data;
					scq_pkg::REG_THICKNESS: thick_q <= cfg.data[30:0];
					default: ;
				endcase
			end

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				scq_pkg::ST_IDLE: begin
					step_q <= '0;
					if (req_fire) begin
						case (req.cmd)
							scq_pkg::CMD_ROW: begin
								if (req.row_index != 2'd3) begin
									for (int c = 0; c < 3; c++) begin
										rot_q[req.row_index][c] <= scq_pkg::sat16(vin[c]);
									end
								end
							end
							scq_pkg::CMD_UPDATE: state_q <= scq_pkg::ST_XFORM;
							scq_pkg::CMD_QUERY:  state_q <= scq_pkg::ST_QMUL;
							default: ;
						endcase
					end
				end
				scq_pkg::ST_XFORM: begin
					step_q <= step_q + 5'd1;
					// a world coordinate is complete with its third product
					if (step_q != 5'd0 && xf_cons.ri == 2'd2) begin
						if (xf_cons.ep) begin
							we_q[xf_cons.col] <= scq_pkg::sat32(72'((acc_n +
								(52'sd1 <<< (scq_pkg::ROT_FRAC_BITS - 1))) >>>
								scq_pkg::ROT_FRAC_BITS) + 72'(pos_q[xf_cons.col]));
						end else begin
							ws_q[xf_cons.col] <= scq_pkg::sat32(72'((acc_n +
								(52'sd1 <<< (scq_pkg::ROT_FRAC_BITS - 1))) >>>
								scq_pkg::ROT_FRAC_BITS) + 72'(pos_q[xf_cons.col]));
						end
					end
					if (step_q == scq_pkg::XF_PRODUCTS) begin
						state_q <= scq_pkg::ST_OUT;
					end
				end
				scq_pkg::ST_QMUL: begin
					step_q <= step_q + 5'd1;
					if (step_q == scq_pkg::QM_PRODUCTS) begin
						state_q <= scq_pkg::ST_DIV;
						step_q  <= '0;
					end
				end
				scq_pkg::ST_DIV: begin
					if (step_q == 5'd0) begin
						if (!(len_q >= scq_pkg::EPS_LEN_SQ) || dot_q[67] || dot_q == '0 ||
							dot_q[66:0] >= len_x) begin
							state_q <= scq_pkg::ST_RAY;
						end else begin
							step_q <= 5'd1;
						end
					end else begin
						step_q <= step_q + 5'd1;
						if (step_q == scq_pkg::DIV_STEPS) begin
							state_q <= scq_pkg::ST_RAY;
							step_q  <= '0;
						end
					end
				end
				scq_pkg::ST_RAY: begin
					step_q <= step_q + 5'd1;
					if (step_q == scq_pkg::RAY_PRODUCTS) begin
						state_q <= scq_pkg::ST_DIST;
						step_q  <= '0;
					end
				end
				scq_pkg::ST_DIST: begin
					step_q <= step_q + 5'd1;
					if (step_q == scq_pkg::DIST_PRODUCTS) begin
						state_q <= scq_pkg::ST_SQRT;
						step_q  <= '0;
					end
				end
				scq_pkg::ST_SQRT: begin
					if (step_q == 5'd0) begin
						step_q <= 5'd1;
					end else if (sq.done) begin
						state_q <= scq_pkg::ST_OUT;
					end
				end
				scq_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= scq_pkg::ST_IDLE;
					end
				end
				default: state_q <= scq_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			scq_pkg::ST_IDLE: begin
				if (req_fire) begin
					is_query_q <= (req.cmd == scq_pkg::CMD_QUERY);
					len_q <= '0;
					dot_q <= '0;
					dn_q  <= '0;
					dr_q  <= '0;
					t_q   <= '0;
					for (int c = 0; c < 3; c++) begin
						pos_q[c] <= vin[c];
						d_q[c]   <= 33'(we_q[c]) - 33'(ws_q[c]);
						w_q[c]   <= 33'(vin[c]) - 33'(ws_q[c]);
					end
				end
			end
			scq_pkg::ST_XFORM: begin
				if (step_q != 5'd0) begin
					acc_q <= acc_n;
				end
			end
			scq_pkg::ST_QMUL: begin
				if (step_q != 5'd0) begin
					if (cons < 5'd3) begin
						len_q <= len_q + prod[65:0];
					end else begin
						dot_q <= dot_q + 68'(prod);
					end
				end
			end
			scq_pkg::ST_DIV: begin
				if (step_q == 5'd0) begin
					ray_ok_q <= (len_q >= scq_pkg::EPS_LEN_SQ);
					rng_q    <= !dot_q[67] && (dot_q[66:0] <= len_x);
					near_s_q <= (len_q < scq_pkg::EPS_SQ);
					rem_q    <= dot_q[66:0];
					if (len_q >= scq_pkg::EPS_LEN_SQ && !dot_q[67] && dot_q != '0 &&
						dot_q[66:0] >= len_x) begin
						t_q <= scq_pkg::T_ONE;
					end
				end else if (rem_sh >= len_x) begin
					rem_q <= rem_sh - len_x;
					t_q   <= {t_q[15:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					t_q   <= {t_q[15:0], 1'b0};
				end
			end
			scq_pkg::ST_RAY: begin
				if (step_q != 5'd0) begin
					ray_q[cons_ln] <= 35'(72'(ws_q[cons_ln]) +
						((prod + 72'sd32768) >>> 16));
				end
			end
			scq_pkg::ST_DIST: begin
				if (step_q != 5'd0) begin
					if (cons < 5'd3) begin
						dn_q <= dn_q + prod[69:0];
					end else if (cons < 5'd6) begin
						dr_q <= dr_q + prod[69:0];
					end else begin
						tsq_q <= prod[61:0];
					end
				end
			end
			scq_pkg::ST_OUT: begin
				if (out_load) begin
					for (int c = 0; c < 3; c++) begin
						if (is_query_q) begin
							box_min_q[c] <= '0;
							box_max_q[c] <= '0;
							near_q[c]    <= scq_pkg::sat32(72'(near_c[c]));
						end else begin
							box_min_q[c] <= scq_pkg::sat32(
								72'((ws_q[c] < we_q[c]) ? ws_q[c] : we_q[c]) -
								signed'(72'({1'b0, thick_q})));
							box_max_q[c] <= scq_pkg::sat32(
								72'((ws_q[c] > we_q[c]) ? ws_q[c] : we_q[c]) +
								signed'(72'({1'b0, thick_q})));
							near_q[c]    <= '0;
						end
					end
					if (is_query_q) begin
						dist_q <= (sq_root[35:31] != '0) ? 31'h7FFF_FFFF : sq_root[30:0];
						hit_q  <= ray_ok_q && rng_q && (dr_q <= {8'd0, tsq_q});
						rt_q   <= (ray_ok_q && rng_q) ? t_q : '0;
					end else begin
						dist_q <= '0;
						hit_q  <= 1'b0;
						rt_q   <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.box_min_x = box_min_q[0];
	assign rsp.box_min_y = box_min_q[1];
	assign rsp.box_min_z = box_min_q[2];
	assign rsp.box_max_x = box_max_q[0];
	assign rsp.box_max_y = box_max_q[1];
	assign rsp.box_max_z = box_max_q[2];
	assign rsp.near_x    = near_q[0];
	assign rsp.near_y    = near_q[1];
	assign rsp.near_z    = near_q[2];
	assign rsp.distance  = dist_q;
	assign rsp.ray_hit   = hit_q;
	assign rsp.ray_t     = rt_q;
endmodule

@@ src/scq_checker.sv @@
// ----------------------------------------------------------------------------
// scq_checker
// Port-level checks of the segment capsule query core, bound to the top.
// ----------------------------------------------------------------------------
`include "segment_capsule_query_core_macros.svh"

module scq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_cmd,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [30:0] rsp_distance,
	input logic        rsp_ray_hit,
	input logic [16:0] rsp_ray_t,
	input logic [31:0] rsp_box_min_x
);
	// a transaction that does arithmetic keeps the core busy
	`SCQ_ASSERT(a_busy_after_work, clk, arst_n, req_valid && req_ready && (req_cmd == scq_pkg::CMD_UPDATE || req_cmd == scq_pkg::CMD_QUERY) |=> !req_ready, "core ready right after an update or query")

	// no result appears the cycle after a command
	`SCQ_ASSERT(a_no_instant_result, clk, arst_n, $rose(rsp_valid) |-> !$past(req_valid && req_ready), "result right after command")

	`SCQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance), "stalled result changed")

	// a hit only comes from a query, whose box fields are zero
	`SCQ_ASSERT_ALWAYS(a_hit_fields, clk, rsp_valid && rsp_ray_hit |-> rsp_box_min_x == 32'd0 && rsp_ray_t <= scq_pkg::T_ONE, "hit result with bad fields")
endmodule

bind segment_capsule_query_core scq_checker u_scq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_cmd       (req.cmd),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_distance  (rsp.distance),
	.rsp_ray_hit   (rsp.ray_hit),
	.rsp_ray_t     (rsp.ray_t),
	.rsp_box_min_x (rsp.box_min_x)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the capsule query core: a queue-fed driver with
// random gaps, a ready-stalling result monitor, and a bit-exact predictor of
// rotation loads, world placement boxes and closest point queries.
// ----------------------------------------------------------------------------
module testbench;
	import scq_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [1:0] ROW_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 600;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0] cmd;
		logic [1:0] row;
		coord_t     vx, vy, vz;
	} cmd_item_t;

	typedef struct {
		coord_t      bmin [3];
		coord_t      bmax [3];
		coord_t      near [3];
		logic [30:0] distance;
		logic        hit;
		logic [16:0] t;
	} answer_t;

	logic clk;
	logic arst_n;

	scq_req_if req ();
	scq_rsp_if rsp ();
	scq_cfg_if cfg ();

	segment_capsule_query_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// predictor state
	longint loc_start [3], loc_end [3], radius;
	longint rot_rows [3][3];
	longint wstart [3], wend [3];

	cmd_item_t cmd_queue [$];
	answer_t   answer_queue [$];

	int  mismatches = 0;
	bit  failed = 0;
	bit  drv_busy = 0;
	int  drv_gap = 0;
	int  rcv_gap = 0;
	bit  calm = 0;
	bit  hold = 0;
	bit  hold_go = 0;
	int  quiet_cycles = 0;
	cmd_item_t cur;

	// stimulus-side copies, used only to aim queries near the segment
	longint gen_start [3], gen_end [3], gen_pos [3];
	longint gen_radius;

	function automatic longint sat_to(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint clamp32(longint v);
		return sat_to(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic void capsule_reset();
		for (int i = 0; i < 3; i++) begin
			loc_start[i] = 0;
			loc_end[i] = 0;
			wstart[i] = 0;
			wend[i] = 0;
			for (int j = 0; j < 3; j++)
				rot_rows[i][j] = (i == j) ? longint'(ONE_ROT) : 0;
		end
		loc_end[1] = 64'sd1 <<< COORD_FRAC_BITS;
		wend[1] = loc_end[1];
		radius = 0;
	endfunction

	function automatic void capsule_write(reg_idx_t idx, logic [31:0] val);
		if (idx <= REG_START_Z) loc_start[idx] = longint'(signed'(val));
		else if (idx <= REG_END_Z) loc_end[idx - REG_END_X] = longint'(signed'(val));
		else radius = longint'(val[30:0]);
	endfunction

	function automatic void place(input longint lp [3], input longint pos [3],
			output longint dst [3]);
		longint s;
		for (int c = 0; c < 3; c++) begin
			s = 0;
			for (int i = 0; i < 3; i++) s += lp[i] * rot_rows[i][c];
			s = (s + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
			dst[c] = clamp32(s + pos[c]);
		end
	endfunction

	function automatic wide_t gap_sq(input longint p [3], input longint q [3]);
		wide_t s, m;
		s = 0;
		for (int c = 0; c < 3; c++) begin
			m = p[c] - q[c];
			s += m * m;
		end
		return s;
	endfunction

	function automatic bit capsule_step(cmd_item_t it, output answer_t a);
		longint v [3], d [3], ray_pt [3], near_pt [3];
		wide_t len_sq, dot, da, db, dsq, cw;
		longint t;
		longint root;
		bit ray_ok, in_range;
		v[0] = it.vx;
		v[1] = it.vy;
		v[2] = it.vz;
		for (int c = 0; c < 3; c++) begin
			a.bmin[c] = 0;
			a.bmax[c] = 0;
			a.near[c] = 0;
		end
		a.distance = 0;
		a.hit = 0;
		a.t = 0;
		case (it.cmd)
			CMD_ROW: begin
				if (it.row != ROW_NOP)
					for (int c = 0; c < 3; c++) rot_rows[it.row][c] = sat_to(v[c], -32768, 32767);
				return 0;
			end
			CMD_UPDATE: begin
				place(loc_start, v, wstart);
				place(loc_end, v, wend);
				for (int c = 0; c < 3; c++) begin
					a.bmin[c] = clamp32((wstart[c] < wend[c] ? wstart[c] : wend[c]) - radius);
					a.bmax[c] = clamp32((wstart[c] > wend[c] ? wstart[c] : wend[c]) + radius);
				end
				return 1;
			end
			CMD_QUERY: begin
				len_sq = 0;
				dot = 0;
				for (int c = 0; c < 3; c++) begin
					d[c] = wend[c] - wstart[c];
					da = d[c];
					db = v[c] - wstart[c];
					len_sq += da * da;
					dot += db * da;
				end
				ray_ok = len_sq >= wide_t'(EPS_LEN_SQ);
				in_range = dot >= 0 && dot <= len_sq;
				t = 0;
				if (ray_ok) begin
					if (dot <= 0) t = 0;
					else if (dot >= len_sq) t = 65536;
					else t = longint'((dot <<< 16) / len_sq);
				end
				for (int c = 0; c < 3; c++) begin
					ray_pt[c] = wstart[c] + ((d[c] * t + (64'sd1 <<< 15)) >>> 16);
					near_pt[c] = (len_sq < wide_t'(EPS_SQ)) ? wstart[c] : ray_pt[c];
					a.near[c] = clamp32(near_pt[c]);
				end
				dsq = gap_sq(v, near_pt);
				root = 0;
				for (int b = 35; b >= 0; b--) begin
					cw = root | (64'sd1 <<< b);
					if (cw * cw <= dsq) root = longint'(cw);
				end
				a.distance = (root > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
				if (ray_ok && in_range) begin
					cw = radius;
					a.hit = gap_sq(v, ray_pt) <= cw * cw;
					a.t = t[16:0];
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// command driver
	initial begin
		req.valid = 0;
		req.cmd = CMD_ROW;
		req.row_index = 0;
		req.vec_x = 0;
		req.vec_y = 0;
		req.vec_z = 0;
	end

	always @(negedge clk) begin
		if (arst_n && !drv_busy) begin
			if (drv_gap > 0) begin
				drv_gap--;
				req.valid = 0;
			end else if (cmd_queue.size() > 0) begin
				cur = cmd_queue.pop_front();
				req.cmd = cur.cmd;
				req.row_index = cur.row;
				req.vec_x = cur.vx;
				req.vec_y = cur.vy;
				req.vec_z = cur.vz;
				req.valid = 1;
				drv_busy = 1;
			end else begin
				req.valid = 0;
			end
		end
	end

	// command transaction: predict and release the driver
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && req.valid && req.ready) begin
			if (capsule_step(cur, a)) answer_queue.push_back(a);
			drv_busy = 0;
			drv_gap = calm ? 0 : $urandom_range(0, 10);
		end
	end

	// result side ready
	initial rsp.ready = 0;

	always @(negedge clk) begin
		if (!arst_n || hold) rsp.ready = 0;
		else if (rcv_gap > 0) begin
			rcv_gap--;
			rsp.ready = 0;
		end else rsp.ready = 1;
	end

	initial begin
		wait (hold_go);
		hold = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold = 0;
	end

	// result monitor
	always @(posedge clk) begin
		answer_t e;
		bit bad;
		if (arst_n && rsp.valid && rsp.ready) begin
			rcv_gap = calm ? 0 : $urandom_range(0, 10);
			if (answer_queue.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
			end else begin
				e = answer_queue.pop_front();
				bad = rsp.box_min_x !== e.bmin[0] || rsp.box_min_y !== e.bmin[1]
					|| rsp.box_min_z !== e.bmin[2] || rsp.box_max_x !== e.bmax[0]
					|| rsp.box_max_y !== e.bmax[1] || rsp.box_max_z !== e.bmax[2]
					|| rsp.near_x !== e.near[0] || rsp.near_y !== e.near[1]
					|| rsp.near_z !== e.near[2] || rsp.distance !== e.distance
					|| rsp.ray_hit !== e.hit || rsp.ray_t !== e.t;
				if (bad) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  exp box %0d %0d %0d / %0d %0d %0d near %0d %0d %0d d %0d h %0d t %0d",
							e.bmin[0], e.bmin[1], e.bmin[2], e.bmax[0], e.bmax[1], e.bmax[2],
							e.near[0], e.near[1], e.near[2], e.distance, e.hit, e.t);
						$display("  got box %0d %0d %0d / %0d %0d %0d near %0d %0d %0d d %0d h %0d t %0d",
							rsp.box_min_x, rsp.box_min_y, rsp.box_min_z, rsp.box_max_x,
							rsp.box_max_y, rsp.box_max_z, rsp.near_x, rsp.near_y, rsp.near_z,
							rsp.distance, rsp.ray_hit, rsp.ray_t);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[segment_capsule_query_core] ERROR");
			$finish;
		end
	end

	task automatic push(logic [1:0] cmd, logic [1:0] row, longint x, longint y, longint z);
		cmd_item_t it;
		it.cmd = cmd;
		it.row = row;
		it.vx = coord_t'(x);
		it.vy = coord_t'(y);
		it.vz = coord_t'(z);
		cmd_queue.push_back(it);
		if (cmd == CMD_UPDATE) begin
			gen_pos[0] = it.vx;
			gen_pos[1] = it.vy;
			gen_pos[2] = it.vz;
		end
	endtask

	task automatic drain();
		wait (cmd_queue.size() == 0 && !drv_busy && answer_queue.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1;
		do @(posedge clk); while (!cfg.ready);
		capsule_write(idx, val);
		if (idx <= REG_START_Z) gen_start[idx] = longint'(signed'(val));
		else if (idx <= REG_END_Z) gen_end[idx - REG_END_X] = longint'(signed'(val));
		else gen_radius = val[30:0];
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic write_all(longint s [3], longint e [3], longint r);
		write_reg(REG_START_X, 32'(s[0]));
		write_reg(REG_START_Y, 32'(s[1]));
		write_reg(REG_START_Z, 32'(s[2]));
		write_reg(REG_END_X, 32'(e[0]));
		write_reg(REG_END_Y, 32'(e[1]));
		write_reg(REG_END_Z, 32'(e[2]));
		write_reg(REG_THICKNESS, 32'(r));
	endtask

	function automatic longint any_coord();
		case ($urandom_range(0, 5))
			0: return longint'(signed'(32'($urandom())));
			1: return $urandom_range(0, 1) ? 64'sd2147483647 - $urandom_range(0, 3)
				: -64'sd2147483648 + $urandom_range(0, 3);
			default: return longint'($urandom_range(0, 2 << 20)) - (1 << 20);
		endcase
	endfunction

	function automatic longint rot_elem();
		case ($urandom_range(0, 7))
			0: return longint'(signed'(32'($urandom())));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return longint'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	task automatic near_query();
		longint p [3];
		longint f;
		longint span;
		f = longint'($urandom_range(0, 1200)) - 100;
		span = gen_radius * 2 + 4;
		if (span > 1 << 22) span = 1 << 22;
		for (int c = 0; c < 3; c++)
			p[c] = gen_pos[c] + gen_start[c] + ((gen_end[c] - gen_start[c]) * f) / 1000
				+ longint'($urandom_range(0, span)) - span / 2;
		push(CMD_QUERY, 2'($urandom_range(0, 3)), p[0], p[1], p[2]);
	endtask

	initial begin
		longint s [3], e [3];
		longint r;
		int n;
		cfg.valid = 0;
		cfg.index = REG_START_X;
		cfg.data = 0;
		capsule_reset();
		for (int i = 0; i < 3; i++) begin
			gen_start[i] = 0;
			gen_end[i] = 0;
			gen_pos[i] = 0;
		end
		gen_end[1] = 65536;
		gen_radius = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset segment from origin to unit y, zero radius
		calm = 1;
		push(CMD_QUERY, 2'd0, 0, 32768, 0);
		push(CMD_QUERY, 2'd0, 100, -65536, 0);
		push(CMD_QUERY, 2'd0, 0, 200000, -5);
		push(CMD_NOP, 2'd0, 1, 2, 3);
		push(CMD_ROW, ROW_NOP, 7, 7, 7);
		push(CMD_QUERY, 2'd0, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
		push(CMD_UPDATE, 2'd0, 0, 0, 0);
		push(CMD_QUERY, 2'd0, 0, 0, 0);
		drain();

		// extreme registers, saturating rotation rows
		s = '{64'sd2147483647, -64'sd2147483648, 0};
		e = '{-64'sd2147483648, 64'sd2147483647, -1};
		write_all(s, e, 64'sd2147483647);
		calm = 0;
		push(CMD_ROW, 2'd0, 64'sd2147483647, -64'sd2147483648, 0);
		push(CMD_ROW, 2'd1, -1, 16384, 64'sd40000);
		push(CMD_ROW, 2'd2, 0, -32768, 32767);
		push(CMD_UPDATE, 2'd0, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
		push(CMD_QUERY, 2'd1, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648);
		push(CMD_QUERY, 2'd2, 0, 0, 0);
		push(CMD_ROW, 2'd0, 16384, 0, 0);
		push(CMD_ROW, 2'd1, 0, 16384, 0);
		push(CMD_ROW, 2'd2, 0, 0, 16384);
		drain();

		// degenerate, tiny and barely long segments
		s = '{1000, 1000, 1000};
		e = '{1000, 1000, 1000};
		write_all(s, e, 0);
		push(CMD_UPDATE, 2'd0, 0, 0, 0);
		push(CMD_QUERY, 2'd0, 5000, -5000, 1000);
		drain();
		e = '{1003, 1000, 1000};
		write_reg(REG_END_X, 32'(e[0]));
		push(CMD_UPDATE, 2'd0, 0, 0, 0);
		push(CMD_QUERY, 2'd0, 1002, 1000, 1000);
		drain();
		e = '{1010, 1000, 1000};
		write_reg(REG_END_X, 32'(e[0]));
		write_reg(REG_THICKNESS, 32'd3);
		push(CMD_UPDATE, 2'd0, 0, 0, 0);
		push(CMD_QUERY, 2'd0, 1005, 1001, 1000);
		push(CMD_QUERY, 2'd0, 1010, 1000, 1000);
		drain();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 3; i++) begin
				s[i] = (ph % 3 == 0) ? any_coord() : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
				e[i] = (ph % 3 == 0) ? any_coord() : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
			end
			r = (ph == 5) ? longint'($urandom() & 32'h7FFF_FFFF) : $urandom_range(0, 1 << 18);
			write_all(s, e, r);
			if (ph == 3) hold_go = 1;
			n = 0;
			while (n < 215) begin
				calm = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 1)) begin
					push(CMD_ROW, 2'd0, 16384, 0, 0);
					push(CMD_ROW, 2'd1, 0, 16384, 0);
					push(CMD_ROW, 2'd2, 0, 0, 16384);
				end else begin
					for (int k = 0; k < 3; k++)
						push(CMD_ROW, 2'(k), rot_elem(), rot_elem(), rot_elem());
				end
				push(CMD_UPDATE, 2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord());
				n += 4;
				for (int q = $urandom_range(2, 8); q > 0; q--) begin
					case ($urandom_range(0, 9))
						0: push(CMD_QUERY, 2'($urandom()), any_coord(), any_coord(), any_coord());
						1: push(CMD_NOP, 2'($urandom()), $urandom(), $urandom(), $urandom());
						2: push(CMD_ROW, ROW_NOP, $urandom(), $urandom(), $urandom());
						default: near_query();
					endcase
					n++;
				end
			end
			drain();
		end
		calm = 0;
		drain();

		if (answer_queue.size() != 0) failed = 1;
		if (!failed) $display("[segment_capsule_query_core] OK");
		else $display("[segment_capsule_query_core] ERROR");
		$finish;
	end

endmodule
